FILE: src/periodic_markov_log_score_assert.svh
// assertion macros for the periodic markov log score block
`ifndef PERIODIC_MARKOV_LOG_SCORE_ASSERT_SVH
`define PERIODIC_MARKOV_LOG_SCORE_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define PMLS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is high
`define PMLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pmls_pkg.sv
// types and constants shared by the periodic markov log score block
`timescale 1ns / 1ps

package pmls_pkg;

  localparam int ENTRY_W = 20;
  localparam int ACC_W = 48;
  localparam int ORDER_W = 3;
  localparam int PERIOD_W = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 3;

  // table geometry, fixed by the item field widths
  localparam int MAX_ORDER = 5;
  localparam int MAX_PERIOD = 3;
  localparam int SYMBOL_BITS = 2;
  localparam int WORD_BITS = SYMBOL_BITS * (MAX_ORDER + 1);
  localparam int TABLE_DEPTH = MAX_PERIOD * (2 ** WORD_BITS);
  localparam int TABLE_ADDR_W = $clog2(TABLE_DEPTH);

  // opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCORE = 1'b1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MODEL_ORDER = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_PERIOD = 1'd1;

  localparam logic [ORDER_W-1:0] MODEL_ORDER_RST = 3'd5;
  localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST = 2'd3;

  // most negative entry marks probability zero
  localparam logic signed [ENTRY_W-1:0] ENTRY_ZERO_PROB = {1'b1, {(ENTRY_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};

  typedef struct packed {
    logic                      opcode;
    logic [1:0]                table_frame;
    logic [WORD_BITS-1:0]      table_word;
    logic signed [ENTRY_W-1:0] table_value;
    logic [SYMBOL_BITS-1:0]    symbol;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] score;
    logic                    saturated;
  } out_item_t;

  // score beat handed from the address stage to the accumulate stage
  typedef struct packed {
    logic valid;
    logic last;
  } pmls_issue_t;

endpackage

FILE: src/periodic_markov_log_score.sv
// Periodic Markov chain log-likelihood scorer. Table-write beats
// (opcode 0) load one signed Q7.12 log2 probability per frame and word; score
// beats (opcode 1) carry one nucleotide each. The block takes one beat per
// cycle unless stalled: a beat reads the table in the cycle it is accepted,
// the saturating 48-bit add follows in the accumulate stage, and the score
// of a sequence is then registered in the result register. Throughput
// is set by the single read port of the table memory, one access per cycle.
// Input stalls during reset and while a final beat waits behind a result
// that has not been taken. A table write followed by a score read of the same
// entry in the next cycle sees the new value. The table has no reset; every
// entry a sequence reaches must be written first.
`timescale 1ns / 1ps
`include "periodic_markov_log_score_assert.svh"

module periodic_markov_log_score import pmls_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // item channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  // register write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [ORDER_W-1:0]        model_order;
  logic [PERIOD_W-1:0]       frame_period;
  logic                      accept;
  logic                      adv;
  logic                      wr_en;
  logic [TABLE_ADDR_W-1:0]   wr_addr;
  logic signed [ENTRY_W-1:0] wr_data;
  logic                      rd_en;
  logic [TABLE_ADDR_W-1:0]   rd_addr;
  logic signed [ENTRY_W-1:0] rd_data;
  pmls_issue_t               issue;

  // registers are always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      model_order <= MODEL_ORDER_RST;
      frame_period <= FRAME_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODEL_ORDER:  model_order <= cfg_data;
        REG_FRAME_PERIOD: frame_period <= PERIOD_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // hold off beats during reset and while the accumulate stage is blocked
  assign in_stall = rst || !adv;
  assign accept = in_valid && !in_stall;

  // address stage
  pmls_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (in_data),
    .model_order  (model_order),
    .frame_period (frame_period),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .issue        (issue)
  );

  // frame-by-word probability memory
  pmls_table #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (TABLE_ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // saturating sum and result register
  pmls_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .rd_data   (rd_data),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // outside reset, input is held off only behind a result that is not taken
  `PMLS_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall,
    "input stalled without a blocked result")

  // a saturated score is pinned to the minimum
  `PMLS_ASSERT_IMPL(a_sat_min, out_valid && out_data.saturated,
    out_data.score == ACC_MIN, "saturated result not at minimum")

  // a fresh result follows a final score beat
  `PMLS_ASSERT_IMPL(a_result_src, $rose(out_valid),
    $past(accept && in_data.opcode == OP_SCORE && in_data.last, 2),
    "result without a final score beat")

endmodule

FILE: src/pmls_front.sv
// address stage: word history, frame counter and table access requests
`timescale 1ns / 1ps

module pmls_front import pmls_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  in_item_t                  item,
  input  logic [ORDER_W-1:0]        model_order,
  input  logic [PERIOD_W-1:0]       frame_period,
  output logic                      wr_en,
  output logic [TABLE_ADDR_W-1:0]   wr_addr,
  output logic signed [ENTRY_W-1:0] wr_data,
  output logic                      rd_en,
  output logic [TABLE_ADDR_W-1:0]   rd_addr,
  output pmls_issue_t               issue
);

  localparam int FRAME_W = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int CNT_W = FRAME_W + 2;

  logic [WORD_BITS-1:0]   word_history;
  logic [WORD_BITS-1:0]   word_history_next;
  logic [WORD_BITS-1:0]   word_mask;
  logic [FRAME_W-1:0]     frame_counter;
  logic [FRAME_W-1:0]     frame_counter_next;
  logic [ORDER_W-1:0]     order_eff;
  logic [CNT_W-1:0]       period_eff;
  logic [CNT_W-1:0]       frame_inc;
  logic                   is_score;
  logic                   frame_ok;

  assign is_score = (item.opcode == OP_SCORE);

  // clamp registers to what the table was built for
  always_comb begin
    order_eff = (model_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : model_order;
    period_eff = (frame_period == '0) ? CNT_W'(1) : CNT_W'(frame_period);
    if (period_eff > CNT_W'(MAX_PERIOD)) begin
      period_eff = CNT_W'(MAX_PERIOD);
    end
  end

  // keep order+1 symbols of history
  always_comb begin
    for (int g = 0; g <= MAX_ORDER; g++) begin
      word_mask[g*SYMBOL_BITS +: SYMBOL_BITS] =
        (ORDER_W'(g) <= order_eff) ? {SYMBOL_BITS{1'b1}} : {SYMBOL_BITS{1'b0}};
    end
  end

  assign word_history_next =
    ((word_history << SYMBOL_BITS) | WORD_BITS'(SYMBOL_BITS'(item.symbol))) & word_mask;

  assign frame_inc = CNT_W'(frame_counter) + CNT_W'(1);
  assign frame_counter_next = (frame_inc >= period_eff) ? '0 : FRAME_W'(frame_inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_history <= '0;
      frame_counter <= '0;
    end else if (accept && is_score) begin
      if (item.last) begin
        word_history <= '0;
        frame_counter <= '0;
      end else begin
        word_history <= word_history_next;
        frame_counter <= frame_counter_next;
      end
    end
  end

  // writes to a frame outside the table are dropped
  assign frame_ok = (CNT_W'(item.table_frame) < CNT_W'(MAX_PERIOD));

  assign wr_en = accept && !is_score && frame_ok;
  assign wr_addr = TABLE_ADDR_W'({FRAME_W'(item.table_frame), WORD_BITS'(item.table_word)});
  assign wr_data = item.table_value;

  assign rd_en = accept && is_score;
  assign rd_addr = TABLE_ADDR_W'({frame_counter, word_history_next});

  assign issue.valid = accept && is_score;
  assign issue.last = item.last;

endmodule

FILE: src/pmls_table.sv
// log probability table, one write port and one registered read port
`timescale 1ns / 1ps

module pmls_table import pmls_pkg::*; #(
  parameter int DEPTH = 12288,
  parameter int ADDR_W = 14
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic signed [ENTRY_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic signed [ENTRY_W-1:0] rd_data
);

  logic signed [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/pmls_accum.sv
// accumulate stage: saturating sum and result register
`timescale 1ns / 1ps

module pmls_accum import pmls_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  pmls_issue_t               issue,
  input  logic signed [ENTRY_W-1:0] rd_data,
  input  logic                      out_stall,
  output logic                      adv,
  output logic                      out_valid,
  output out_item_t                 out_data
);

  localparam logic signed [ACC_W:0] SUM_MIN = {ACC_MIN[ACC_W-1], ACC_MIN};
  localparam logic signed [ACC_W:0] SUM_MAX = {ACC_MAX[ACC_W-1], ACC_MAX};

  logic                    s1_valid;
  logic                    s1_last;
  logic                    s1_fire;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic                    sat;
  logic                    sat_next;
  logic signed [ACC_W:0]   sum;

  // only a final beat needs a free result register
  assign adv = !(s1_valid && s1_last && out_valid && out_stall);
  assign s1_fire = s1_valid && adv;

  assign sum = (ACC_W+1)'(acc) + (ACC_W+1)'(rd_data);

  always_comb begin
    acc_next = acc;
    sat_next = sat;
    if (rd_data == ENTRY_ZERO_PROB || sat) begin
      acc_next = ACC_MIN;
      sat_next = 1'b1;
    end else if (sum <= SUM_MIN) begin
      acc_next = ACC_MIN;
      sat_next = 1'b1;
    end else if (sum > SUM_MAX) begin
      acc_next = ACC_MAX;
    end else begin
      acc_next = ACC_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      acc <= '0;
      sat <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid <= issue.valid;
      end
      if (s1_fire) begin
        if (s1_last) begin
          acc <= '0;
          sat <= 1'b0;
        end else begin
          acc <= acc_next;
          sat <= sat_next;
        end
      end
      if (s1_fire && s1_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last <= issue.last;
    end
    if (s1_fire && s1_last) begin
      out_data.score <= acc_next;
      out_data.saturated <= sat_next;
    end
  end

endmodule
